### rtl/ws2812_pixel_line_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// WS2812 line encoder assertion macros
// Shared concurrent assertion forms for the encoder top level.
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_LINE_ENCODER_TOP_DEFINES_SVH
`define WS2812_PIXEL_LINE_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WPLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define WPLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wple_pkg.sv
// ----------------------------------------------------------------------------
// wple_pkg
// Types, constants and helpers shared by the WS2812 line encoder.
// ----------------------------------------------------------------------------
package wple_pkg;

   localparam int PIXEL_BITS  = 24;
   localparam int WordW       = 24;
   localparam int BitsLeftW   = 5;
   localparam int PeriodW     = 12;
   localparam int LatchW      = 16;
   localparam int CsrDataW    = 16;
   localparam int CsrIndexW   = 2;

   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   localparam logic [PeriodW-1:0] BitPeriodReset = PeriodW'(97);
   localparam logic [PeriodW-1:0] ZeroHighReset  = PeriodW'(19);
   localparam logic [PeriodW-1:0] OneHighReset   = PeriodW'(38);
   localparam logic [LatchW-1:0]  LatchLowReset  = LatchW'(2403);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEND  = 2'd1,
      PH_LATCH = 2'd2
   } phase_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_BIT_PERIOD = 2'd0,
      CSR_ZERO_HIGH  = 2'd1,
      CSR_ONE_HIGH   = 2'd2,
      CSR_LATCH_LOW  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             pixel_valid;
      logic [WordW-1:0] pixel_word;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic pixel_ready;
      logic busy_res;
      logic underrun;
   } rsp_type;

   // high time for the bit now at the top of the shifter
   function automatic logic [PeriodW-1:0] high_for(
      input logic               msb,
      input logic [PeriodW-1:0] one_high,
      input logic [PeriodW-1:0] zero_high
   );
      return msb ? one_high : zero_high;
   endfunction

endpackage

### rtl/ws2812_pixel_line_encoder_top.sv
// ----------------------------------------------------------------------------
// ws2812_pixel_line_encoder_top
// WS2812 serial line encoder: one waveform tick per transaction.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload               | direction
//   --------+--------------------+-----------------------+----------
//   req     | req_push/req_full  | req_item (req_type)   | in
//   rsp     | rsp_pop/rsp_empty  | rsp_item (rsp_type)   | out
//   csr     | csr_valid/ready    | csr_index, csr_data   | in
//
// One tick in, one result out, one per cycle sustained while the result queue
// has room. An accepted tick is written into the request queue; the engine
// evaluates it at the queue head and pushes its result into the result queue,
// whose head drives rsp_item until popped. Reset is synchronous: queues empty,
// timing registers take their defaults. A full result queue stops the engine
// and req_full rises after at most two more ticks. csr_ready is always high.
//
module ws2812_pixel_line_encoder_top import wple_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // tick transactions
   input  logic                req_push,
   input  req_type             req_item,
   output logic                req_full,
   // result transactions
   input  logic                rsp_pop,
   output rsp_type             rsp_item,
   output logic                rsp_empty,
   // register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

`include "ws2812_pixel_line_encoder_top_defines.svh"

   // front-to-back link
   logic    tick_empty;
   logic    tick_pop;
   req_type tick_item;

   // back-to-result link
   logic    res_full;
   logic    res_push;
   rsp_type res_item;

   assign csr_ready = 1'b1;

   // front: buffers ticks so the source never waits on the engine directly
   wple_req_queue u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (req_item),
      .full      (req_full),
      .pop       (tick_pop),
      .empty     (tick_empty),
      .head      (tick_item)
   );

   // back: waveform sequencer and timing registers
   wple_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (tick_empty),
      .in_item   (tick_item),
      .in_pop    (tick_pop),
      .out_full  (res_full),
      .out_push  (res_push),
      .out_item  (res_item),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // results wait here until popped
   wple_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_item (res_item),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_item)
   );

   // engine must advance whenever a tick waits and there is room for its result
   `WPLE_ASSERT_SAME(a_engine_no_stall, clock, reset, !tick_empty && !res_full, tick_pop, "engine idled with work and room")

   // a taken pixel must come from a tick that offered one
   `WPLE_ASSERT_SAME(a_ready_needs_pixel, clock, reset, res_push && res_item.pixel_ready, tick_item.pixel_valid, "pixel_ready without offered pixel")

   // a produced result is visible on the result side at the next cycle
   `WPLE_ASSERT_NEXT(a_result_lands, clock, reset, res_push, !rsp_empty, "result lost after engine push")

endmodule

### rtl/wple_req_queue.sv
// ----------------------------------------------------------------------------
// wple_req_queue
// Front queue: takes tick transactions and holds them for the engine.
// ----------------------------------------------------------------------------
module wple_req_queue import wple_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type head
);

   req_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QueueCntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/wple_rsp_queue.sv
// ----------------------------------------------------------------------------
// wple_rsp_queue
// Result queue: holds engine results until the consumer pops them.
// ----------------------------------------------------------------------------
module wple_rsp_queue import wple_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == QueueCntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/wple_engine.sv
// ----------------------------------------------------------------------------
// wple_engine
// Back end: waveform sequencer, one tick per cycle while the result side has room, plus timing registers.
// ----------------------------------------------------------------------------
module wple_engine import wple_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // tick side
   input  logic                in_empty,
   input  req_type             in_item,
   output logic                in_pop,
   // result side
   input  logic                out_full,
   output logic                out_push,
   output rsp_type             out_item,
   // register writes
   input  logic                csr_write,
   input  csr_index_type       csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   logic [PeriodW-1:0]    bit_period_ff, zero_high_ff, one_high_ff;
   logic [LatchW-1:0]     latch_low_ff;

   phase_type             phase_ff, phase_in;
   logic [PIXEL_BITS-1:0] bit_shift_ff, bit_shift_in;
   logic [BitsLeftW-1:0]  bits_left_ff, bits_left_in;
   logic [PeriodW-1:0]    period_count_ff, period_count_in;
   logic [PeriodW-1:0]    high_time_ff, high_time_in;
   logic [LatchW-1:0]     latch_count_ff, latch_count_in;
   logic                  last_pixel_ff, last_pixel_in;

   logic                  fire;
   logic                  latch_hold, sending, boundary, last_bit;
   logic                  do_shift, do_latch, do_take, do_under;
   logic [PeriodW:0]      next_count;
   logic [PIXEL_BITS-1:0] shifted, taken;

   assign fire     = !in_empty && !out_full;
   assign in_pop   = fire;
   assign out_push = fire;

   // classify the tick
   assign latch_hold = (phase_ff == PH_LATCH) && (latch_count_ff < latch_low_ff);
   assign sending    = (phase_ff == PH_SEND);
   assign next_count = {1'b0, period_count_ff} + 1'b1;
   assign boundary   = (next_count >= {1'b0, bit_period_ff});
   assign last_bit   = (bits_left_ff == '0);
   assign do_shift   = sending && boundary && !last_bit;
   assign do_latch   = sending && boundary && last_bit && last_pixel_ff;
   assign do_take    = in_item.pixel_valid &&
                       ((sending && boundary && last_bit && !last_pixel_ff) ||
                        (!sending && !latch_hold));
   assign do_under   = sending && boundary && last_bit && !last_pixel_ff &&
                       !in_item.pixel_valid;
   assign shifted    = {bit_shift_ff[PIXEL_BITS-2:0], 1'b0};
   assign taken      = PIXEL_BITS'(in_item.pixel_word);

   // next state
   always_comb begin
      phase_in        = phase_ff;
      bit_shift_in    = bit_shift_ff;
      bits_left_in    = bits_left_ff;
      period_count_in = period_count_ff;
      high_time_in    = high_time_ff;
      latch_count_in  = latch_count_ff;
      last_pixel_in   = last_pixel_ff;
      if (latch_hold) begin
         latch_count_in = latch_count_ff + 1'b1;
      end else if (sending && !boundary) begin
         period_count_in = next_count[PeriodW-1:0];
      end else if (do_shift) begin
         bit_shift_in    = shifted;
         bits_left_in    = bits_left_ff - 1'b1;
         period_count_in = '0;
         high_time_in    = high_for(shifted[PIXEL_BITS-1], one_high_ff, zero_high_ff);
      end else if (do_latch) begin
         phase_in        = PH_LATCH;
         latch_count_in  = LatchW'(1);
         last_pixel_in   = 1'b0;
         high_time_in    = '0;
         period_count_in = '0;
      end else if (do_take) begin
         phase_in        = PH_SEND;
         bit_shift_in    = taken;
         bits_left_in    = BitsLeftW'(PIXEL_BITS - 1);
         last_pixel_in   = in_item.frame_end;
         period_count_in = '0;
         high_time_in    = high_for(taken[PIXEL_BITS-1], one_high_ff, zero_high_ff);
      end else if (do_under) begin
         bit_shift_in    = '0;
         high_time_in    = '0;
         period_count_in = '0;
      end else if (!sending) begin
         phase_in = PH_IDLE;
      end
   end

   // result of this tick
   always_comb begin
      out_item.line_level  = (phase_in == PH_SEND) && (period_count_in < high_time_in);
      out_item.pixel_ready = do_take;
      out_item.busy_res    = latch_hold || sending || do_take;
      out_item.underrun    = do_under;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_shift_ff    <= '0;
         bits_left_ff    <= '0;
         period_count_ff <= '0;
         high_time_ff    <= '0;
         latch_count_ff  <= '0;
         last_pixel_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         bit_shift_ff    <= bit_shift_in;
         bits_left_ff    <= bits_left_in;
         period_count_ff <= period_count_in;
         high_time_ff    <= high_time_in;
         latch_count_ff  <= latch_count_in;
         last_pixel_ff   <= last_pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BitPeriodReset;
         zero_high_ff  <= ZeroHighReset;
         one_high_ff   <= OneHighReset;
         latch_low_ff  <= LatchLowReset;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BIT_PERIOD: bit_period_ff <= csr_data[PeriodW-1:0];
            CSR_ZERO_HIGH:  zero_high_ff  <= csr_data[PeriodW-1:0];
            CSR_ONE_HIGH:   one_high_ff   <= csr_data[PeriodW-1:0];
            CSR_LATCH_LOW:  latch_low_ff  <= csr_data[LatchW-1:0];
            default: ;
         endcase
      end
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// ws2812_pixel_line_encoder_top testbench
// Drives waveform ticks, some of them carrying GRB pixels, into the line
// encoder and checks every per-tick result (line level, pixel taken, busy,
// underrun) against a tick-by-tick model of the encoder. Timing registers
// are reprogrammed between phases, ending with the largest values.
// ----------------------------------------------------------------------------
module testbench;
   import wple_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // time to let the encoder settle around a register write, and at the end
   localparam int SettleCycles = 8;
   // hard stop; the slowest correct run is far below this
   localparam int CycleLimit   = 1_000_000;
   localparam int IdlePct      = 24;
   // receiver backs off for this long every StallEvery results
   localparam int StallEvery   = 700;
   localparam int StallCycles  = 250;

   // -------------------------------------------------------------------------
   // Tick-accurate encoder model plus the queue of predicted line samples.
   // -------------------------------------------------------------------------
   class line_tick_scoreboard;
      logic [PeriodW-1:0]    period_len, zero_high, one_high;
      logic [LatchW-1:0]     latch_len;
      logic [PIXEL_BITS-1:0] shifter;
      logic [BitsLeftW-1:0]  bits_left;
      logic [PeriodW-1:0]    period_pos, high_time;
      logic [LatchW-1:0]     latch_pos;
      logic                  last_pixel;
      phase_type             phase;
      rsp_type               expected_samples[$];
      int                    mismatch_count;

      function new();
         period_len     = BitPeriodReset;
         zero_high      = ZeroHighReset;
         one_high       = OneHighReset;
         latch_len      = LatchLowReset;
         shifter        = '0;
         bits_left      = '0;
         period_pos     = '0;
         high_time      = '0;
         latch_pos      = '0;
         last_pixel     = 1'b0;
         phase          = PH_IDLE;
         mismatch_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CsrDataW-1:0] data);
         case (idx)
            CSR_BIT_PERIOD: period_len = data[PeriodW-1:0];
            CSR_ZERO_HIGH:  zero_high  = data[PeriodW-1:0];
            CSR_ONE_HIGH:   one_high   = data[PeriodW-1:0];
            CSR_LATCH_LOW:  latch_len  = data[LatchW-1:0];
            default: ;
         endcase
      endfunction

      // high time follows the bit now at the top of the shifter
      function void pick_high_time();
         high_time = shifter[PIXEL_BITS-1] ? one_high : zero_high;
      endfunction

      function void load_pixel(req_type t);
         shifter    = PIXEL_BITS'(t.pixel_word);
         bits_left  = BitsLeftW'(PIXEL_BITS - 1);
         last_pixel = t.frame_end;
         period_pos = '0;
         phase      = PH_SEND;
         pick_high_time();
      endfunction

      // would a pixel offered on the next tick be taken
      function bit will_take_pixel();
         case (phase)
            PH_SEND:
               return ({1'b0, period_pos} + 13'd1 >= {1'b0, period_len}) &&
                      bits_left == '0 && !last_pixel;
            PH_LATCH: return latch_pos >= latch_len;
            default:  return 1'b1;
         endcase
      endfunction

      // advance one tick and queue the line sample it produces
      function void note_tick(req_type t);
         rsp_type     r;
         logic [12:0] next_pos;
         r = '0;
         if (phase == PH_LATCH) begin
            if (latch_pos < latch_len) begin
               latch_pos = latch_pos + 1'b1;
               r.busy_res = 1'b1;
               expected_samples.push_back(r);
               return;
            end
            phase = PH_IDLE;
         end
         if (phase == PH_SEND) begin
            next_pos = {1'b0, period_pos} + 13'd1;
            if (next_pos >= {1'b0, period_len}) begin
               if (bits_left != '0) begin
                  shifter    = shifter << 1;
                  bits_left  = bits_left - 1'b1;
                  period_pos = '0;
                  pick_high_time();
               end else if (last_pixel) begin
                  // frame done: hold the line low for the latch time
                  phase      = PH_LATCH;
                  latch_pos  = LatchW'(1);
                  last_pixel = 1'b0;
                  high_time  = '0;
                  period_pos = '0;
                  r.busy_res = 1'b1;
                  expected_samples.push_back(r);
                  return;
               end else if (t.pixel_valid) begin
                  load_pixel(t);
                  r.pixel_ready = 1'b1;
               end else begin
                  // nothing to send: an all-low period
                  shifter    = '0;
                  high_time  = '0;
                  period_pos = '0;
                  r.underrun = 1'b1;
               end
            end else begin
               period_pos = next_pos[PeriodW-1:0];
            end
            r.busy_res = 1'b1;
         end else begin
            phase = PH_IDLE;
            if (t.pixel_valid) begin
               load_pixel(t);
               r.pixel_ready = 1'b1;
               r.busy_res    = 1'b1;
            end
         end
         r.line_level = (phase == PH_SEND) && (period_pos < high_time);
         expected_samples.push_back(r);
      endfunction

      function void compare_bit(string field, logic want, logic got);
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 30)
               $display("%0t ns: %s mismatch, expected %b, got %b",
                        $time, field, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 30)
               $display("%0t ns: unexpected result, expected none, got %b", $time, got);
            return;
         end
         want = expected_samples.pop_front();
         compare_bit("line_level",  want.line_level,  got.line_level);
         compare_bit("pixel_ready", want.pixel_ready, got.pixel_ready);
         compare_bit("busy_res",    want.busy_res,    got.busy_res);
         compare_bit("underrun",    want.underrun,    got.underrun);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_push  = 1'b0;
   req_type             req_item  = '0;
   logic                req_full;
   logic                rsp_pop   = 1'b0;
   rsp_type             rsp_item;
   logic                rsp_empty;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_index_type       csr_index = CSR_BIT_PERIOD;
   logic [CsrDataW-1:0] csr_data  = '0;

   // no random idling on either side while set
   bit                  calm = 1'b0;
   int                  cycle_count = 0;

   line_tick_scoreboard sb = new();

   ws2812_pixel_line_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("ws2812_pixel_line_encoder_top regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side. Pops at random, checks each popped transaction, and every
   // StallEvery results stops popping for a long stretch so the result queue
   // fills, the engine stalls and req_full backs up onto the sender.
   // -------------------------------------------------------------------------
   initial begin : result_sink
      int results_seen;
      int hold_left;
      results_seen = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            sb.check_result(rsp_item);
            results_seen++;
            if (results_seen % StallEvery == 0)
               hold_left = StallCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= calm || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tick side. send_tick leaves req_push high after an accept, so back-to-
   // back transactions never lower and raise it in the same step; the model
   // is advanced here, in the sending process, so the stimulus can look at
   // the encoder's phase before building the next tick.
   // -------------------------------------------------------------------------
   task automatic send_tick(input req_type t);
      while (!calm && $urandom_range(99) < IdlePct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= t;
      do @(posedge clock); while (req_full);
      sb.note_tick(t);
   endtask

   // stop offering ticks, wait for every predicted sample, then let it settle
   task automatic drain_and_settle();
      req_push <= 1'b0;
      while (sb.expected_samples.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // program all four timing registers; the 12-bit ones get junk in the top
   // nibble, which the block must drop
   task automatic apply_settings(input int period, input int zero_t,
                                 input int one_t, input int latch_t);
      logic [CsrDataW-1:0] vals[4];
      csr_index_type       idx;
      drain_and_settle();
      vals[0] = {4'($urandom_range(15)), 12'(period)};
      vals[1] = {4'($urandom_range(15)), 12'(zero_t)};
      vals[2] = {4'($urandom_range(15)), 12'(one_t)};
      vals[3] = CsrDataW'(latch_t);
      idx = CSR_BIT_PERIOD;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, vals[i]);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
      repeat (SettleCycles) @(posedge clock);
   endtask

   // mostly well-formed feeding: offer a pixel at nearly every point where
   // one can be taken (leaving one out mid-frame gives an underrun), and now and then
   // one mid-pixel or mid-latch, which must be refused
   function automatic req_type random_tick(int fend_pct);
      req_type t;
      if (sb.will_take_pixel())
         t.pixel_valid = $urandom_range(99) < 85;
      else
         t.pixel_valid = $urandom_range(99) < 15;
      case ($urandom_range(9))
         0:       t.pixel_word = '0;
         1:       t.pixel_word = '1;
         default: t.pixel_word = WordW'($urandom);
      endcase
      t.frame_end = $urandom_range(99) < fend_pct;
      return t;
   endfunction

   task automatic run_random(input int count, input int fend_pct);
      repeat (count) send_tick(random_tick(fend_pct));
   endtask

   // blank ticks up to the next point where a pixel is taken; the first busy
   // tick offers a decoy pixel marked frame end, which must be ignored
   task automatic walk_to_boundary(input logic [WordW-1:0] decoy);
      req_type t;
      bit      offered;
      offered = 1'b0;
      while (!sb.will_take_pixel()) begin
         t = '{pixel_valid: !offered, pixel_word: decoy, frame_end: 1'b1};
         send_tick(t);
         offered = 1'b1;
      end
   endtask

   // all-zero and all-one pixels, alternating patterns, an underrun period
   // between two pixels, and frame ends that run into the latch time
   task automatic run_directed();
      logic [WordW-1:0] words[5];
      logic             fends[5];
      req_type          t;
      words = '{24'h000000, 24'hFFFFFF, 24'hA5A5A5, 24'h5A5A5A, 24'h800001};
      fends = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      for (int i = 0; i < 5; i++) begin
         walk_to_boundary(~words[i]);
         if (i == 3 && sb.phase == PH_SEND) begin
            // skip one boundary on purpose
            t = '{pixel_valid: 1'b0, pixel_word: words[i], frame_end: 1'b0};
            send_tick(t);
            walk_to_boundary(words[i]);
         end
         t = '{pixel_valid: 1'b1, pixel_word: words[i], frame_end: fends[i]};
         send_tick(t);
      end
   endtask

   // -------------------------------------------------------------------------
   // Run plan: reset defaults first, then directed and random ticks under a
   // range of timings (tiny periods, period below two, zero high time, high
   // time past the period, zero latch, full-scale latch and period).
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing values, partway into the first pixel
      run_random(150, 10);

      apply_settings(3, 1, 2, 4);
      run_directed();
      run_random(150, 15);

      apply_settings(1, 0, 4095, 0);
      run_directed();
      run_random(150, 15);

      apply_settings(0, 5, 0, 3);
      run_random(100, 15);

      // stretch without idling on either side
      apply_settings(5, 2, 4, 20);
      calm = 1'b1;
      run_random(250, 10);
      calm = 1'b0;

      apply_settings(4, 1, 3, 9);
      run_random(200, 12);

      // every pixel ends a frame
      apply_settings(2, 1, 2, 40);
      run_random(150, 100);

      // full-scale bit period and latch
      apply_settings(4095, 4095, 2000, 65535);
      run_random(100, 10);

      drain_and_settle();
      if (sb.mismatch_count == 0 && sb.expected_samples.size() == 0) begin
         $display("ws2812_pixel_line_encoder_top regression: pass");
      end else begin
         $display("ws2812_pixel_line_encoder_top regression: fail");
      end
      $finish;
   end

endmodule
